// ===== hdl/svu_pkg.sv =====
// Shared types and constants for the staggered-grid velocity update block.
// Depends on nothing; svu_ctrl, svu_dp, the top level, svu_check and the testbench import it.
package svu_pkg;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] stress_xx;
    logic signed [31:0] stress_yy;
    logic signed [31:0] stress_zz;
    logic signed [31:0] stress_xy;
    logic signed [31:0] stress_yz;
    logic signed [31:0] stress_xz;
    logic [30:0]        density_x;
    logic [30:0]        density_y;
    logic [30:0]        density_z;
  } in_item_t;

  typedef struct packed {
    logic [27:0]        point_index;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic               last_interior;
    logic               divide_fault;
  } out_item_t;

  // One slot of the point window: stresses, velocities and densities.
  typedef struct packed {
    logic signed [31:0] s_xx;
    logic signed [31:0] s_yy;
    logic signed [31:0] s_zz;
    logic signed [31:0] s_xy;
    logic signed [31:0] s_yz;
    logic signed [31:0] s_xz;
    logic signed [31:0] v_x;
    logic signed [31:0] v_y;
    logic signed [31:0] v_z;
    logic [30:0]        d_x;
    logic [30:0]        d_y;
    logic [30:0]        d_z;
  } ring_word_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HALO   = 3'd6;

  // Neighbor slots read from the window.
  localparam int NB_COUNT = 6;
  localparam logic [2:0] NB_C  = 3'd0;
  localparam logic [2:0] NB_ZP = 3'd1;
  localparam logic [2:0] NB_ZM = 3'd2;
  localparam logic [2:0] NB_XP = 3'd3;
  localparam logic [2:0] NB_XM = 3'd4;
  localparam logic [2:0] NB_YM = 3'd5;

  // Scaled stress-difference terms, three per velocity.
  localparam int TERM_COUNT = 9;
  localparam logic [3:0] T_X_XX = 4'd0;
  localparam logic [3:0] T_X_XY = 4'd1;
  localparam logic [3:0] T_X_XZ = 4'd2;
  localparam logic [3:0] T_Y_YY = 4'd3;
  localparam logic [3:0] T_Y_XY = 4'd4;
  localparam logic [3:0] T_Y_YZ = 4'd5;
  localparam logic [3:0] T_Z_ZZ = 4'd6;
  localparam logic [3:0] T_Z_XZ = 4'd7;
  localparam logic [3:0] T_Z_YZ = 4'd8;

  localparam int SW   = 51;       // sum of three scaled terms
  localparam int NW   = SW + 16;  // dividend width
  localparam int DENW = 31;

  typedef struct packed {
    logic       latch;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       cap_en;
    logic [2:0] cap_sel;
    logic       mul_en;
    logic [3:0] mul_sel;
    logic       acc_en;
    logic       div_start;
    logic       finish;
    logic       commit;
    logic       push;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/svu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module svu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/svu_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
module svu_div #(
  parameter int NW   = 67,
  parameter int DENW = 31
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NW-1:0]   dividend,
  input  logic [DENW-1:0] divisor,
  output logic            busy,
  output logic [NW-1:0]   quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0]   cnt;
  logic [DENW-1:0] rem;
  logic [DENW-1:0] den;
  logic [DENW:0]   rem_sh;
  logic            ge;

  always_comb begin
    rem_sh = {rem, quotient[NW-1]};
    ge     = rem_sh >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= CW'(NW);
      quotient <= dividend;
      rem      <= '0;
      den      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[NW-2:0], ge};
      rem      <= ge ? DENW'(rem_sh - {1'b0, den}) : rem_sh[DENW-1:0];
      cnt      <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/svu_ctrl.sv =====
// Sequencer for the velocity update: read, multiply, divide, commit, push; boundary points only commit.
// Depends on svu_pkg.
module svu_ctrl import svu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_READ   = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_DSTART = 4'd4;
  localparam logic [3:0] S_DWAIT  = 4'd5;
  localparam logic [3:0] S_FIN    = 4'd6;
  localparam logic [3:0] S_COMMIT = 4'd7;
  localparam logic [3:0] S_PUSH   = 4'd8;

  logic [3:0] state, state_next;
  logic [3:0] cnt, cnt_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cnt_next   = '0;
        state_next = sts.emit ? S_READ : S_COMMIT;
      end
      S_READ: begin
        cmd.rd_en   = cnt < 4'(NB_COUNT);
        cmd.rd_sel  = cnt[2:0];
        cmd.cap_en  = cnt != 4'd0;
        cmd.cap_sel = 3'(cnt - 4'd1);
        cnt_next    = cnt + 4'd1;
        if (cnt == 4'(NB_COUNT)) begin
          cnt_next   = '0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en  = cnt < 4'(TERM_COUNT);
        cmd.mul_sel = cnt;
        cmd.acc_en  = cnt != 4'd0;
        cnt_next    = cnt + 4'd1;
        if (cnt == 4'(TERM_COUNT)) begin
          cnt_next   = '0;
          state_next = S_DSTART;
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = sts.emit ? S_PUSH : S_IDLE;
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== hdl/svu_dp.sv =====
// Datapath: registers, point window, multiplier, dividers, output register.
// Depends on svu_pkg, svu_ram and svu_div.
module svu_dp import svu_pkg::*; #(
  parameter int MAX_DIM_Z = 64,
  parameter int MAX_DIM_X = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  localparam int RING_DEPTH = 2 * MAX_DIM_Z * MAX_DIM_X;
  localparam int AW         = $clog2(RING_DEPTH);
  localparam int DW         = AW + 1;

  logic [31:0] coef_x, coef_y, coef_z;
  logic [6:0]  dim_z, dim_x;
  logic [15:0] dim_y;
  logic [4:0]  halo;

  logic [6:0]  nz, nx;
  logic [15:0] ny;
  logic [4:0]  h;

  logic [6:0]  pos_z, pos_x;
  logic [15:0] pos_y;
  logic [6:0]  ez, ex, pz_n, px_n;
  logic [15:0] ey, ety, py_n;
  logic        wrap, emit_c;

  logic [AW-1:0] wptr;
  in_item_t      in_q;
  logic          emit_q;
  logic [DW-1:0] slice_q;

  // geometry: zero acts as one, oversize z and x clamp to the window size
  always_comb begin
    nz = (dim_z == 7'd0) ? 7'd1 : ((int'(dim_z) > MAX_DIM_Z) ? 7'(MAX_DIM_Z) : dim_z);
    nx = (dim_x == 7'd0) ? 7'd1 : ((int'(dim_x) > MAX_DIM_X) ? 7'(MAX_DIM_X) : dim_x);
    ny = (dim_y == 16'd0) ? 16'd1 : dim_y;
    h  = (halo == 5'd0) ? 5'd1 : halo;
  end

  always_comb begin
    wrap   = (pos_z >= nz) || (pos_x >= nx) || (pos_y >= ny);
    ez     = wrap ? '0 : pos_z;
    ex     = wrap ? '0 : pos_x;
    ey     = wrap ? '0 : pos_y;
    ety    = ey - 16'd1;
    emit_c = (ey != 16'd0)
          && (ety >= 16'(h)) && (17'(ety) + 17'(h) < 17'(ny))
          && (ex >= 7'(h)) && (8'(ex) + 8'(h) < 8'(nx))
          && (ez >= 7'(h)) && (8'(ez) + 8'(h) < 8'(nz));
  end

  // next raster position
  always_comb begin
    pz_n = pos_z + 7'd1;
    px_n = pos_x;
    py_n = pos_y;
    if (8'(pos_z) + 8'd1 >= 8'(nz)) begin
      pz_n = '0;
      px_n = pos_x + 7'd1;
      if (8'(pos_x) + 8'd1 >= 8'(nx)) begin
        px_n = '0;
        py_n = pos_y + 16'd1;
        if (17'(pos_y) + 17'd1 >= 17'(ny)) begin
          py_n = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x <= 32'd65536;
      coef_y <= 32'd65536;
      coef_z <= 32'd65536;
      dim_z  <= 7'd64;
      dim_x  <= 7'd64;
      dim_y  <= 16'd64;
      halo   <= 5'd1;
      pos_z  <= '0;
      pos_x  <= '0;
      pos_y  <= '0;
      wptr   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COEF_X: coef_x <= cfg_data;
          REG_COEF_Y: coef_y <= cfg_data;
          REG_COEF_Z: coef_z <= cfg_data;
          REG_DIM_Z: begin
            dim_z <= cfg_data[6:0];
            pos_z <= '0; pos_x <= '0; pos_y <= '0;
          end
          REG_DIM_X: begin
            dim_x <= cfg_data[6:0];
            pos_z <= '0; pos_x <= '0; pos_y <= '0;
          end
          REG_DIM_Y: begin
            dim_y <= cfg_data[15:0];
            pos_z <= '0; pos_x <= '0; pos_y <= '0;
          end
          REG_HALO: begin
            halo  <= cfg_data[4:0];
            pos_z <= '0; pos_x <= '0; pos_y <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.latch) begin
        pos_z <= ez;
        pos_x <= ex;
        pos_y <= ey;
      end
      if (cmd.commit) begin
        pos_z <= pz_n;
        pos_x <= px_n;
        pos_y <= py_n;
        wptr  <= (int'(wptr) == RING_DEPTH - 1) ? '0 : wptr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_q    <= in_data;
      emit_q  <= emit_c;
      slice_q <= DW'(nz) * DW'(nx);
    end
  end

  // window read address: distance back from the write slot, wrapped once
  logic [DW-1:0] back_dist, strip, wext;
  logic [AW-1:0] raddr;
  ring_word_t    wword, rword;

  always_comb begin
    strip = DW'(nz);
    unique case (cmd.rd_sel)
      NB_C:    back_dist = slice_q;
      NB_ZP:   back_dist = slice_q - DW'(1);
      NB_ZM:   back_dist = slice_q + DW'(1);
      NB_XP:   back_dist = slice_q - strip;
      NB_XM:   back_dist = slice_q + strip;
      NB_YM:   back_dist = DW'(slice_q << 1);
      default: back_dist = slice_q;
    endcase
    wext  = DW'(wptr);
    raddr = (wext >= back_dist) ? AW'(wext - back_dist)
                                : AW'(wext + DW'(RING_DEPTH) - back_dist);
  end

  always_comb begin
    wword.s_xx = in_q.stress_xx;
    wword.s_yy = in_q.stress_yy;
    wword.s_zz = in_q.stress_zz;
    wword.s_xy = in_q.stress_xy;
    wword.s_yz = in_q.stress_yz;
    wword.s_xz = in_q.stress_xz;
    wword.v_x  = in_q.vel_x;
    wword.v_y  = in_q.vel_y;
    wword.v_z  = in_q.vel_z;
    wword.d_x  = in_q.density_x;
    wword.d_y  = in_q.density_y;
    wword.d_z  = in_q.density_z;
  end

  svu_ram #(
    .WIDTH($bits(ring_word_t)),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (cmd.commit),
    .waddr(wptr),
    .wdata(wword),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(rword)
  );

  ring_word_t nb [NB_COUNT];

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      nb[cmd.cap_sel] <= rword;
    end
  end

  // one scaled difference per cycle
  logic signed [31:0] op_a, op_b;
  logic [31:0]        op_c;
  logic [1:0]         op_t;
  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [64:0]        prod_full;
  logic [63:0]        prod_q;
  logic               neg_q;
  logic [1:0]         tgt_q;

  always_comb begin
    op_a = nb[NB_C].s_xx;
    op_b = nb[NB_C].s_xx;
    op_c = coef_x;
    op_t = 2'd0;
    unique case (cmd.mul_sel)
      T_X_XX: begin op_a = nb[NB_XP].s_xx; op_b = nb[NB_C].s_xx;  op_c = coef_x; op_t = 2'd0; end
      T_X_XY: begin op_a = nb[NB_C].s_xy;  op_b = nb[NB_YM].s_xy; op_c = coef_y; op_t = 2'd0; end
      T_X_XZ: begin op_a = nb[NB_C].s_xz;  op_b = nb[NB_ZM].s_xz; op_c = coef_z; op_t = 2'd0; end
      T_Y_YY: begin op_a = in_q.stress_yy; op_b = nb[NB_C].s_yy;  op_c = coef_y; op_t = 2'd1; end
      T_Y_XY: begin op_a = nb[NB_C].s_xy;  op_b = nb[NB_XM].s_xy; op_c = coef_x; op_t = 2'd1; end
      T_Y_YZ: begin op_a = nb[NB_C].s_yz;  op_b = nb[NB_ZM].s_yz; op_c = coef_z; op_t = 2'd1; end
      T_Z_ZZ: begin op_a = nb[NB_ZP].s_zz; op_b = nb[NB_C].s_zz;  op_c = coef_z; op_t = 2'd2; end
      T_Z_XZ: begin op_a = nb[NB_C].s_xz;  op_b = nb[NB_XM].s_xz; op_c = coef_x; op_t = 2'd2; end
      T_Z_YZ: begin op_a = nb[NB_C].s_yz;  op_b = nb[NB_YM].s_yz; op_c = coef_y; op_t = 2'd2; end
      default: ;
    endcase
    diff      = {op_a[31], op_a} - {op_b[31], op_b};
    mag       = diff[32] ? 33'(-diff) : 33'(diff);
    prod_full = mag * op_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_q <= prod_full[63:0];
      neg_q  <= diff[32];
      tgt_q  <= op_t;
    end
  end

  // negative terms round toward minus infinity
  logic [47:0]          sh48;
  logic signed [SW-1:0] term;
  logic signed [SW-1:0] sum_q [3];

  always_comb begin
    sh48 = neg_q ? 48'((prod_q + 64'h0000_0000_0000_FFFF) >> 16) : prod_q[63:16];
    term = neg_q ? -$signed(SW'(sh48)) : $signed(SW'(sh48));
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sum_q[0] <= '0;
      sum_q[1] <= '0;
      sum_q[2] <= '0;
    end else if (cmd.acc_en) begin
      sum_q[tgt_q] <= sum_q[tgt_q] + term;
    end
  end

  logic [SW-1:0]   smag [3];
  logic [DENW-1:0] den  [3];
  logic [NW-1:0]   quo  [3];
  logic [2:0]      busy;

  always_comb begin
    den[0] = nb[NB_C].d_x;
    den[1] = nb[NB_C].d_y;
    den[2] = nb[NB_C].d_z;
    for (int i = 0; i < 3; i++) begin
      smag[i] = sum_q[i][SW-1] ? SW'(-sum_q[i]) : SW'(sum_q[i]);
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    svu_div #(
      .NW  (NW),
      .DENW(DENW)
    ) u_div (
      .clk     (clk),
      .rst     (rst),
      .start   (cmd.div_start),
      .dividend({smag[g], 16'd0}),
      .divisor (den[g]),
      .busy    (busy[g]),
      .quotient(quo[g])
    );
  end

  // {fault, value}: saturate quotient, then saturate v + quotient
  function automatic logic [32:0] axis_result(input logic signed [31:0] v,
                                              input logic signed [SW-1:0] s,
                                              input logic [DENW-1:0] dv,
                                              input logic [NW-1:0] qm);
    logic signed [31:0] q;
    logic signed [32:0] t;
    logic [31:0]        r;
    logic               f;
    f = 1'b0;
    if (dv == '0) begin
      f = 1'b1;
      if (s == '0) begin
        q = '0;
      end else if (s[SW-1]) begin
        q = 32'sh8000_0000;
      end else begin
        q = 32'sh7FFF_FFFF;
      end
    end else if (s[SW-1]) begin
      if ((qm[NW-1:32] != '0) || (qm[31] && (qm[30:0] != '0))) begin
        q = 32'sh8000_0000;
        f = 1'b1;
      end else begin
        q = $signed(~qm[31:0] + 32'd1);
      end
    end else begin
      if (qm[NW-1:31] != '0) begin
        q = 32'sh7FFF_FFFF;
        f = 1'b1;
      end else begin
        q = $signed(qm[31:0]);
      end
    end
    t = {v[31], v} + {q[31], q};
    if (t[32:31] == 2'b01) begin
      r = 32'h7FFF_FFFF;
      f = 1'b1;
    end else if (t[32:31] == 2'b10) begin
      r = 32'h8000_0000;
      f = 1'b1;
    end else begin
      r = t[31:0];
    end
    return {f, r};
  endfunction

  logic [32:0] rx, ry, rz;
  logic [15:0] ty;
  logic [31:0] idx_full;
  logic        last_c;
  out_item_t   res_q;

  always_comb begin
    rx       = axis_result(nb[NB_C].v_x, sum_q[0], den[0], quo[0]);
    ry       = axis_result(nb[NB_C].v_y, sum_q[1], den[1], quo[1]);
    rz       = axis_result(nb[NB_C].v_z, sum_q[2], den[2], quo[2]);
    ty       = pos_y - 16'd1;
    idx_full = 32'(ty) * 32'(slice_q) + 32'(pos_x) * 32'(nz) + 32'(pos_z);
    last_c   = (17'(ty) + 17'(h) + 17'd1 == 17'(ny))
            && (8'(pos_x) + 8'(h) + 8'd1 == 8'(nx))
            && (8'(pos_z) + 8'(h) + 8'd1 == 8'(nz));
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_q.point_index   <= idx_full[27:0];
      res_q.new_vel_x     <= $signed(rx[31:0]);
      res_q.new_vel_y     <= $signed(ry[31:0]);
      res_q.new_vel_z     <= $signed(rz[31:0]);
      res_q.last_interior <= last_c;
      res_q.divide_fault  <= rx[32] | ry[32] | rz[32];
    end
    if (cmd.push) begin
      out_data <= res_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.emit     = emit_q;
    sts.div_done = ~|busy;
    sts.out_free = ~out_valid | out_ready;
  end

endmodule

// ===== hdl/staggered_velocity_update_3d.sv =====
// Top level of the streaming 3-D staggered-grid velocity update.
// Depends on svu_pkg, svu_ctrl and svu_dp (which holds svu_ram and svu_div).
//
//   channel  direction  handshake              payload
//   in       request in  in_valid / in_ready   in_data  (in_item_t)
//   out      request out out_valid / out_ready out_data (out_item_t)
//   cfg      write in    cfg_we                cfg_index, cfg_data
//
// A boundary point passes through accept, decide and commit. An interior point
// passes through accept, decide, the window reads, the multiply/accumulate steps,
// divider start, the wait on the bit-serial dividers (67 quotient bits, three run
// side by side), finish, commit and push; the dividers dominate.
// Synchronous active-high reset clears control, registers and positions; the
// window memory is not cleared (the stream order never reads unwritten slots).
// A full output register holds the next request in the push step until taken.
module staggered_velocity_update_3d import svu_pkg::*; #(
  parameter int MAX_DIM_Z = 64,
  parameter int MAX_DIM_X = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  svu_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // datapath: window memory, shared multiplier, dividers, output register
  svu_dp #(
    .MAX_DIM_Z(MAX_DIM_Z),
    .MAX_DIM_X(MAX_DIM_X)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== hdl/svu_check.sv =====
// Port-level checks for the velocity update block, bound to the top level.
// Depends on svu_pkg.
module svu_check import svu_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one request at a time: ready drops after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accept");

  // with no result pending, none can appear in the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind staggered_velocity_update_3d svu_check u_check (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// ===== bench/tb_staggered_velocity_update_3d.sv =====
// Testbench for staggered_velocity_update_3d: streams grids of points through the block,
// predicts every updated interior point and checks each request that leaves the block.
// Depends on svu_pkg and the RTL of the block; reads no files.
`timescale 1ns / 100ps

module tb_staggered_velocity_update_3d;
  import svu_pkg::*;

  localparam int MAX_Z        = 64;
  localparam int MAX_X        = 64;
  localparam int WINDOW_DEPTH = 2 * MAX_Z * MAX_X + 1;
  // Drain time after the last expected update; leave margin for the output hold.
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES  = 600;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // past the register list, ignored
  localparam longint S32_MAX  = 64'sd2147483647;
  localparam longint S32_MIN  = -64'sd2147483648;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  staggered_velocity_update_3d #(
    .MAX_DIM_Z(MAX_Z),
    .MAX_DIM_X(MAX_X)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Generous ceiling: several times the slowest legal run.
  initial begin
    #40_000_000;
    $display("staggered_velocity_update_3d test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the registers, the point window and the
  // position of the next arriving point.
  // ---------------------------------------------------------------------------
  logic [31:0] coef_x = 32'd65536, coef_y = 32'd65536, coef_z = 32'd65536;
  logic [6:0]  dim_z = 7'd64, dim_x = 7'd64;
  logic [15:0] dim_y = 16'd64;
  logic [4:0]  halo = 5'd1;
  in_item_t    window [WINDOW_DEPTH];
  int unsigned wr_slot = 0, pos_z = 0, pos_x = 0, pos_y = 0;

  out_item_t   pending_updates[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_request = 1'b0;
  int          hold_left = 0;

  function automatic logic signed [31:0] clamp_s32(longint v, inout bit fault);
    if (v > S32_MAX) begin
      fault = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < S32_MIN) begin
      fault = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // (a-b)*coef exactly, then divide by 2^16 rounding toward minus infinity.
  function automatic longint scaled_term(logic signed [31:0] a, logic signed [31:0] b,
                                         logic [31:0] coef);
    longint     d;
    bit [63:0]  mag, prod;
    d = longint'(a) - longint'(b);
    mag = (d < 0) ? -d : d;
    prod = mag * {32'd0, coef};
    if (d < 0) return -longint'((prod + 64'hFFFF) >> 16);
    return longint'(prod >> 16);
  endfunction

  // v + sum*2^16/den, quotient truncated toward zero; zero density saturates.
  function automatic logic signed [31:0] new_velocity(logic signed [31:0] v, longint sum,
                                                      logic [30:0] den, inout bit fault);
    longint    q;
    bit [63:0] mag, dd, qh, rem, qm;
    if (den == '0) begin
      fault = 1'b1;
      q = (sum > 0) ? S32_MAX : ((sum < 0) ? S32_MIN : 0);
    end else begin
      mag = (sum < 0) ? -sum : sum;
      dd = {33'd0, den};
      qh = mag / dd;
      rem = mag % dd;
      if (qh >= 64'h1_0000_0000) begin
        q = (sum < 0) ? -(64'sd1 <<< 48) : (64'sd1 <<< 48);
      end else begin
        qm = (qh << 16) + ((rem << 16) / dd);
        q = (sum < 0) ? -longint'(qm) : longint'(qm);
      end
      q = clamp_s32(q, fault);
    end
    return clamp_s32(longint'(v) + q, fault);
  endfunction

  function automatic int unsigned slot_back(int unsigned back);
    return (wr_slot + WINDOW_DEPTH - (back % WINDOW_DEPTH)) % WINDOW_DEPTH;
  endfunction

  // Store one accepted point, emit the point one slice behind if interior, advance.
  task automatic predict_update(input in_item_t pt);
    int unsigned nz, nx, ny, h, strip, slice, ty, tx, tz;
    in_item_t    c, zp, zm, xp, xm, ym, yp;
    longint      sx, sy, sz;
    bit          fault;
    out_item_t   upd;
    nz = (dim_z == 0) ? 1 : ((dim_z > MAX_Z) ? MAX_Z : dim_z);
    nx = (dim_x == 0) ? 1 : ((dim_x > MAX_X) ? MAX_X : dim_x);
    ny = (dim_y == 0) ? 1 : dim_y;
    h = (halo == 0) ? 1 : halo;
    strip = nz;
    slice = nz * nx;
    if (pos_z >= nz || pos_x >= nx || pos_y >= ny) begin
      pos_z = 0;
      pos_x = 0;
      pos_y = 0;
    end
    window[wr_slot] = pt;
    if (pos_y >= 1) begin
      ty = pos_y - 1;
      tx = pos_x;
      tz = pos_z;
      if (ty >= h && ty + h < ny && tx >= h && tx + h < nx && tz >= h && tz + h < nz) begin
        c  = window[slot_back(slice)];
        zp = window[slot_back(slice - 1)];
        zm = window[slot_back(slice + 1)];
        xp = window[slot_back(slice - strip)];
        xm = window[slot_back(slice + strip)];
        ym = window[slot_back(2 * slice)];
        yp = window[wr_slot];
        fault = 1'b0;
        sx = scaled_term(xp.stress_xx, c.stress_xx, coef_x)
           + scaled_term(c.stress_xy, ym.stress_xy, coef_y)
           + scaled_term(c.stress_xz, zm.stress_xz, coef_z);
        sy = scaled_term(yp.stress_yy, c.stress_yy, coef_y)
           + scaled_term(c.stress_xy, xm.stress_xy, coef_x)
           + scaled_term(c.stress_yz, zm.stress_yz, coef_z);
        sz = scaled_term(zp.stress_zz, c.stress_zz, coef_z)
           + scaled_term(c.stress_xz, xm.stress_xz, coef_x)
           + scaled_term(c.stress_yz, ym.stress_yz, coef_y);
        upd.new_vel_x = new_velocity(c.vel_x, sx, c.density_x, fault);
        upd.new_vel_y = new_velocity(c.vel_y, sy, c.density_y, fault);
        upd.new_vel_z = new_velocity(c.vel_z, sz, c.density_z, fault);
        upd.point_index = 28'(ty * slice + tx * strip + tz);
        upd.last_interior = (ty + h + 1 == ny && tx + h + 1 == nx && tz + h + 1 == nz);
        upd.divide_fault = fault;
        pending_updates.push_back(upd);
      end
    end
    pos_z++;
    if (pos_z >= nz) begin
      pos_z = 0;
      pos_x++;
      if (pos_x >= nx) begin
        pos_x = 0;
        pos_y++;
        if (pos_y >= ny) pos_y = 0;
      end
    end
    wr_slot = (wr_slot + 1) % WINDOW_DEPTH;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: the receiver stalls at random, or holds off for a long
  // stretch on request, and every accepted request is checked in order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_updates
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_updates.size() == 0) begin
        $display("%0t unexpected request: expected none, actual index %0d", $time,
                 out_data.point_index);
        mismatches++;
      end else begin
        want = pending_updates.pop_front();
        if (out_data.point_index !== want.point_index) begin
          $display("%0t point_index expected %0d actual %0d", $time,
                   want.point_index, out_data.point_index);
          mismatches++;
        end
        if (out_data.new_vel_x !== want.new_vel_x) begin
          $display("%0t new_vel_x expected %0d actual %0d", $time,
                   want.new_vel_x, out_data.new_vel_x);
          mismatches++;
        end
        if (out_data.new_vel_y !== want.new_vel_y) begin
          $display("%0t new_vel_y expected %0d actual %0d", $time,
                   want.new_vel_y, out_data.new_vel_y);
          mismatches++;
        end
        if (out_data.new_vel_z !== want.new_vel_z) begin
          $display("%0t new_vel_z expected %0d actual %0d", $time,
                   want.new_vel_z, out_data.new_vel_z);
          mismatches++;
        end
        if (out_data.last_interior !== want.last_interior) begin
          $display("%0t last_interior expected %0b actual %0b", $time,
                   want.last_interior, out_data.last_interior);
          mismatches++;
        end
        if (out_data.divide_fault !== want.divide_fault) begin
          $display("%0t divide_fault expected %0b actual %0b", $time,
                   want.divide_fault, out_data.divide_fault);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side and configuration.
  // ---------------------------------------------------------------------------

  // Offer one point; hold valid and payload until accepted. Valid stays high
  // when the next point follows with no gap, so it is never dropped and raised
  // in the same step.
  task automatic send_point(input in_item_t pt);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= pt;
    do @(posedge clk); while (!in_ready);
    predict_update(pt);
  endtask

  // Drop valid, drain every expected update, then let any boundary point finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register and mirror it; the caller drops cfg_we after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_COEF_X: coef_x = val;
      REG_COEF_Y: coef_y = val;
      REG_COEF_Z: coef_z = val;
      REG_DIM_Z:  dim_z = val[6:0];
      REG_DIM_X:  dim_x = val[6:0];
      REG_DIM_Y:  dim_y = val[15:0];
      REG_HALO:   halo = val[4:0];
      default:    return;
    endcase
    // Any geometry write starts a new grid.
    if (idx != REG_COEF_X && idx != REG_COEF_Y && idx != REG_COEF_Z) begin
      pos_z = 0;
      pos_x = 0;
      pos_y = 0;
    end
  endtask

  task automatic set_grid(input int dz, input int dx, input int dy, input int h);
    write_reg(REG_DIM_Z, dz);
    write_reg(REG_DIM_X, dx);
    write_reg(REG_DIM_Y, dy);
    write_reg(REG_HALO, h);
    cfg_we <= 1'b0;
  endtask

  task automatic set_coefs(input logic [31:0] cx, input logic [31:0] cy,
                           input logic [31:0] cz);
    write_reg(REG_COEF_X, cx);
    write_reg(REG_COEF_Y, cy);
    write_reg(REG_COEF_Z, cz);
    cfg_we <= 1'b0;
  endtask

  // Mostly moderate values so sums stay in range, with full-range and extremes mixed in.
  function automatic logic signed [31:0] rand_s32();
    case ($urandom_range(7))
      0, 1:    return $urandom;
      2:       return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $signed($urandom_range(32'h3FFFF)) - 32'sh1FFFF;
    endcase
  endfunction

  function automatic logic [30:0] rand_density();
    case ($urandom_range(15))
      0:       return '0;
      1:       return 31'($urandom_range(255));
      2:       return 31'($urandom);
      default: return 31'($urandom_range(32'h40000, 32'h8000));
    endcase
  endfunction

  function automatic in_item_t random_point();
    in_item_t pt;
    pt.vel_x = rand_s32();
    pt.vel_y = rand_s32();
    pt.vel_z = rand_s32();
    pt.stress_xx = rand_s32();
    pt.stress_yy = rand_s32();
    pt.stress_zz = rand_s32();
    pt.stress_xy = rand_s32();
    pt.stress_yz = rand_s32();
    pt.stress_xz = rand_s32();
    pt.density_x = rand_density();
    pt.density_y = rand_density();
    pt.density_z = rand_density();
    return pt;
  endfunction

  function automatic logic signed [31:0] pick_extreme();
    case ($urandom_range(4))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic logic [30:0] pick_density();
    case ($urandom_range(3))
      0:       return '0;
      1:       return 31'd1;
      2:       return 31'h7FFFFFFF;
      default: return 31'd65536;
    endcase
  endfunction

  function automatic in_item_t extreme_point();
    in_item_t pt;
    pt.vel_x = pick_extreme();
    pt.vel_y = pick_extreme();
    pt.vel_z = pick_extreme();
    pt.stress_xx = pick_extreme();
    pt.stress_yy = pick_extreme();
    pt.stress_zz = pick_extreme();
    pt.stress_xy = pick_extreme();
    pt.stress_yz = pick_extreme();
    pt.stress_xz = pick_extreme();
    pt.density_x = pick_density();
    pt.density_y = pick_density();
    pt.density_z = pick_density();
    return pt;
  endfunction

  function automatic logic [31:0] rand_coef();
    return $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h30000, 32'h4000);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Smallest grid with an interior, streamed twice so the position wraps.
  task automatic test_smallest_grid();
    set_coefs(32'd65536, 32'd65536, 32'd65536);
    set_grid(3, 3, 3, 1);
    repeat (54) send_point(random_point());
    wait_idle();
  endtask

  // Coefficient extremes with extreme stresses, velocities and densities:
  // zero density, quotient overflow and velocity saturation all show up here.
  task automatic test_value_extremes();
    set_grid(3, 3, 3, 1);
    for (int k = 0; k < 4; k++) begin
      case (k)
        0:       set_coefs(32'd0, 32'd0, 32'd0);
        1:       set_coefs(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        2:       set_coefs(32'd1, 32'hFFFFFFFF, 32'd65536);
        default: set_coefs(32'd65536, 32'd0, 32'hFFFFFFFF);
      endcase
      repeat (27) send_point(extreme_point());
      wait_idle();
    end
  endtask

  // Zero and oversized dimensions, halo extremes, a huge y extent, an ignored
  // register index and a restart in the middle of a grid.
  task automatic test_geometry_edges();
    set_coefs(rand_coef(), rand_coef(), rand_coef());
    set_grid(0, 0, 0, 0);
    repeat (6) send_point(random_point());
    wait_idle();
    set_grid(127, 3, 3, 1);
    repeat (3 * 64 * 2 + 40) send_point(random_point());
    wait_idle();
    set_grid(3, 127, 3, 1);
    repeat (3 * 64 * 2 + 40) send_point(random_point());
    wait_idle();
    set_grid(4, 4, 65535, 31);
    repeat (40) send_point(random_point());
    wait_idle();
    set_grid(5, 5, 65535, 1);
    repeat (100) send_point(random_point());
    wait_idle();
    set_grid(5, 5, 5, 2);
    repeat (125) send_point(random_point());
    wait_idle();
    write_reg(REG_SPARE, $urandom);
    cfg_we <= 1'b0;
    set_grid(4, 4, 4, 0);
    repeat (30) send_point(random_point());
    wait_idle();
    set_grid(4, 4, 4, 0);
    repeat (64) send_point(random_point());
    wait_idle();
  endtask

  // Random small grids, mostly streamed whole, some cut short.
  task automatic test_random_grids(input int idle_pct, input int stall_pct, input bit hold);
    int left, dz, dx, dy, h, n;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    left = 100;
    while (left > 0) begin
      dz = $urandom_range(7, 3);
      dx = $urandom_range(7, 3);
      dy = $urandom_range(6, 3);
      h = (dz >= 5 && dx >= 5 && dy >= 5 && $urandom_range(1)) ? 2 : 1;
      set_coefs(rand_coef(), rand_coef(), rand_coef());
      set_grid(dz, dx, dy, h);
      n = dz * dx * dy;
      if ($urandom_range(4) == 0) n = $urandom_range(n, 1);
      // Stall the output long enough to back the block up into its input.
      if (hold) begin
        hold_request = 1'b1;
        hold = 1'b0;
      end
      repeat (n) send_point(random_point());
      left -= n;
      wait_idle();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_smallest_grid();
    test_value_extremes();
    test_geometry_edges();
    test_random_grids(0, 0, 1'b1);
    test_random_grids(80, 0, 1'b0);
    test_random_grids(0, 80, 1'b0);
    test_random_grids(22, 22, 1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_idle();
    if (mismatches == 0) begin
      $display("staggered_velocity_update_3d test passed");
    end else begin
      $display("staggered_velocity_update_3d test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/svu_pkg.sv
hdl/svu_ram.sv
hdl/svu_div.sv
hdl/svu_ctrl.sv
hdl/svu_dp.sv
hdl/staggered_velocity_update_3d.sv
hdl/svu_check.sv
bench/tb_staggered_velocity_update_3d.sv
